@@ rtl/core/segmented_colormap_lookup_defines.svh @@
// assertion macros shared by the colormap lookup rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef SEGMENTED_COLORMAP_LOOKUP_DEFINES_SVH
`define SEGMENTED_COLORMAP_LOOKUP_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define SCL_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SCL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/scl_pkg.sv @@
// shared types, sizes and codes for the segmented colormap lookup
// no dependencies; used by scl_divider and segmented_colormap_lookup
`timescale 1ns / 1ps
`default_nettype none

package scl_pkg;

    // table geometry
    localparam int MAX_POINTS = 16;
    localparam int NUM_CH     = 3;
    localparam int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int ADDR_W     = $clog2(NUM_CH * MAX_POINTS);

    // field widths
    localparam int DATA_W    = 17;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int PTS_W     = 5;
    localparam int CH_W      = 2;
    localparam int PIDX_W    = 4;
    localparam int CFG_IDX_W = 2;

    // divider iteration count, one quotient bit per step
    localparam int DIV_STEPS = DATA_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // item modes
    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    // channel codes; a load on the unused code is dropped
    localparam logic [CH_W-1:0] CH_RED    = 2'd0;
    localparam logic [CH_W-1:0] CH_GREEN  = 2'd1;
    localparam logic [CH_W-1:0] CH_BLUE   = 2'd2;
    localparam logic [CH_W-1:0] CH_UNUSED = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RED_POINTS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN_POINTS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUE_POINTS  = 2'd2;

    typedef logic [DATA_W-1:0] level_t;

    // one breakpoint as held in the table memory
    typedef struct packed {
        level_t key;
        level_t below;
        level_t above;
    } point_t;

    // divider status towards the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    // sequencer states
    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_READ   = 7'b0000010,
        ST_CHECK  = 7'b0000100,
        ST_MUL    = 7'b0001000,
        ST_LAUNCH = 7'b0010000,
        ST_DIV    = 7'b0100000,
        ST_FIN    = 7'b1000000
    } state_t;

endpackage

`default_nettype wire

@@ rtl/core/segmented_colormap_lookup.sv @@
// lookup: per channel each breakpoint scanned passes the read and check states, plus
// multiply, launch and the 17-step divider when the sample falls between two points;
// a load is written into the table while the sequencer is idle
// one item at a time: the scan reads one table slot per memory access
// synchronous active-low reset clears control and sets all point counts to 1;
// table contents are undefined until loaded
`timescale 1ns / 1ps
`default_nettype none
`include "segmented_colormap_lookup_defines.svh"

module segmented_colormap_lookup (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // configuration write port
    input  wire logic                          cfg_we,
    input  wire logic [scl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [scl_pkg::PTS_W-1:0]     cfg_wdata,
    // input items
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_mode,
    input  wire logic [scl_pkg::CH_W-1:0]      s_channel,
    input  wire logic [scl_pkg::PIDX_W-1:0]    s_point_index,
    input  wire logic [scl_pkg::DATA_W-1:0]    s_point_key,
    input  wire logic [scl_pkg::DATA_W-1:0]    s_level_below,
    input  wire logic [scl_pkg::DATA_W-1:0]    s_level_above,
    input  wire logic [scl_pkg::DATA_W-1:0]    s_sample,
    // results
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [scl_pkg::DATA_W-1:0]         m_red,
    output logic [scl_pkg::DATA_W-1:0]         m_green,
    output logic [scl_pkg::DATA_W-1:0]         m_blue
);

    localparam int DEPTH = scl_pkg::NUM_CH * scl_pkg::MAX_POINTS;

    scl_pkg::state_t               state_reg, state_next;
    logic [scl_pkg::CH_W-1:0]      ch_reg, ch_next;
    logic [scl_pkg::IDX_W-1:0]     i_reg, i_next;
    logic [scl_pkg::PTS_W-1:0]     points_reg [scl_pkg::NUM_CH];
    logic                          m_valid_reg, m_valid_next;

    scl_pkg::level_t               sample_reg, sample_next;
    scl_pkg::level_t               prev_key_reg, prev_key_next;
    scl_pkg::level_t               prev_above_reg, prev_above_next;
    scl_pkg::level_t               span_reg, span_next;
    scl_pkg::level_t               off_reg, off_next;
    scl_pkg::level_t               diff_reg, diff_next;
    scl_pkg::level_t               lo_reg, lo_next;
    logic                          neg_reg, neg_next;
    logic [scl_pkg::PROD_W-1:0]    prod_reg, prod_next;
    scl_pkg::level_t               lvl_reg [scl_pkg::NUM_CH];
    scl_pkg::level_t               red_reg, green_reg, blue_reg;

    scl_pkg::point_t               point_mem_reg [DEPTH];
    scl_pkg::point_t               rd_data_reg;
    logic [scl_pkg::ADDR_W-1:0]    rd_addr;
    logic [scl_pkg::ADDR_W-1:0]    wr_addr;
    logic                          wr_en;

    logic [scl_pkg::PTS_W-1:0]     n_raw;
    logic [scl_pkg::CNT_W-1:0]     n_use;
    logic [scl_pkg::CNT_W-1:0]     i_ext;
    logic [scl_pkg::CNT_W-1:0]     idx_inc;
    logic                          key_hit;
    logic                          out_free;
    logic                          chan_done;
    scl_pkg::level_t               chan_level;
    scl_pkg::level_t               lerp;
    logic                          div_start;
    scl_pkg::level_t               div_quot;
    scl_pkg::div_status_t          div_stat;

    // shared iterative divider for the interpolation step
    scl_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (span_reg),
        .quotient (div_quot),
        .status   (div_stat)
    );

    assign s_ready   = (state_reg == scl_pkg::ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_red     = red_reg;
    assign m_green   = green_reg;
    assign m_blue    = blue_reg;
    assign out_free  = !m_valid_reg || m_ready;
    assign div_start = (state_reg == scl_pkg::ST_LAUNCH);

    // points in use for the channel being scanned, zero taken as one, counts above MAX_POINTS clipped
    always_comb begin
        n_raw = points_reg[ch_reg];
        if (n_raw == '0) begin
            n_use = scl_pkg::CNT_W'(1);
        end else if (int'(n_raw) > scl_pkg::MAX_POINTS) begin
            n_use = scl_pkg::CNT_W'(scl_pkg::MAX_POINTS);
        end else begin
            n_use = scl_pkg::CNT_W'(n_raw);
        end
    end

    // scan addressing, load addressing, key compare and interpolated level
    always_comb begin
        i_ext   = scl_pkg::CNT_W'(i_reg);
        idx_inc = i_ext + 1'b1;
        rd_addr = scl_pkg::ADDR_W'(int'(ch_reg) * scl_pkg::MAX_POINTS)
                + scl_pkg::ADDR_W'(i_reg);
        wr_addr = scl_pkg::ADDR_W'(int'(s_channel) * scl_pkg::MAX_POINTS)
                + scl_pkg::ADDR_W'(s_point_index);
        wr_en   = s_valid && s_ready && (s_mode == scl_pkg::MODE_LOAD)
                && (s_channel != scl_pkg::CH_UNUSED)
                && (int'(s_point_index) < scl_pkg::MAX_POINTS);
        key_hit = rd_data_reg.key > sample_reg;
        lerp    = neg_reg ? (lo_reg - div_quot) : (lo_reg + div_quot);
    end

    // sequencer and datapath next values
    always_comb begin
        state_next      = state_reg;
        ch_next         = ch_reg;
        i_next          = i_reg;
        m_valid_next    = m_valid_reg;
        sample_next     = sample_reg;
        prev_key_next   = prev_key_reg;
        prev_above_next = prev_above_reg;
        span_next       = span_reg;
        off_next        = off_reg;
        diff_next       = diff_reg;
        lo_next         = lo_reg;
        neg_next        = neg_reg;
        prod_next       = prod_reg;
        chan_done       = 1'b0;
        chan_level      = lerp;

        // result register drains independently of the sequencer
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            scl_pkg::ST_IDLE: begin
                if (s_valid && (s_mode == scl_pkg::MODE_LOOKUP)) begin
                    sample_next = s_sample;
                    ch_next     = scl_pkg::CH_RED;
                    i_next      = '0;
                    state_next  = scl_pkg::ST_READ;
                end
            end
            scl_pkg::ST_READ: begin
                state_next = scl_pkg::ST_CHECK;
            end
            scl_pkg::ST_CHECK: begin
                if (key_hit) begin
                    if (i_reg == '0) begin
                        chan_level = rd_data_reg.below;
                        chan_done  = 1'b1;
                    end else begin
                        // sample lies between the previous point and this one
                        span_next  = rd_data_reg.key - prev_key_reg;
                        off_next   = sample_reg - prev_key_reg;
                        lo_next    = prev_above_reg;
                        neg_next   = rd_data_reg.below < prev_above_reg;
                        diff_next  = (rd_data_reg.below < prev_above_reg)
                                   ? (prev_above_reg - rd_data_reg.below)
                                   : (rd_data_reg.below - prev_above_reg);
                        state_next = scl_pkg::ST_MUL;
                    end
                end else begin
                    prev_key_next   = rd_data_reg.key;
                    prev_above_next = rd_data_reg.above;
                    if (idx_inc == n_use) begin
                        chan_level = rd_data_reg.above;
                        chan_done  = 1'b1;
                    end else begin
                        i_next     = scl_pkg::IDX_W'(idx_inc);
                        state_next = scl_pkg::ST_READ;
                    end
                end
            end
            scl_pkg::ST_MUL: begin
                prod_next  = scl_pkg::PROD_W'(diff_reg) * scl_pkg::PROD_W'(off_reg);
                state_next = scl_pkg::ST_LAUNCH;
            end
            scl_pkg::ST_LAUNCH: begin
                state_next = scl_pkg::ST_DIV;
            end
            scl_pkg::ST_DIV: begin
                if (div_stat.done) begin
                    chan_level = lerp;
                    chan_done  = 1'b1;
                end
            end
            scl_pkg::ST_FIN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = scl_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = scl_pkg::ST_IDLE;
            end
        endcase

        // move on to the next channel or to the result
        if (chan_done) begin
            i_next = '0;
            if (ch_reg == scl_pkg::CH_BLUE) begin
                state_next = scl_pkg::ST_FIN;
            end else begin
                ch_next    = ch_reg + 1'b1;
                state_next = scl_pkg::ST_READ;
            end
        end
    end

    // control state and point counts
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= scl_pkg::ST_IDLE;
            ch_reg      <= scl_pkg::CH_RED;
            i_reg       <= '0;
            m_valid_reg <= 1'b0;
            for (int k = 0; k < scl_pkg::NUM_CH; k++) begin
                points_reg[k] <= scl_pkg::PTS_W'(1);
            end
        end else begin
            state_reg   <= state_next;
            ch_reg      <= ch_next;
            i_reg       <= i_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we && (cfg_index == scl_pkg::CFG_RED_POINTS)) begin
                points_reg[0] <= cfg_wdata;
            end
            if (cfg_we && (cfg_index == scl_pkg::CFG_GREEN_POINTS)) begin
                points_reg[1] <= cfg_wdata;
            end
            if (cfg_we && (cfg_index == scl_pkg::CFG_BLUE_POINTS)) begin
                points_reg[2] <= cfg_wdata;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        sample_reg     <= sample_next;
        prev_key_reg   <= prev_key_next;
        prev_above_reg <= prev_above_next;
        span_reg       <= span_next;
        off_reg        <= off_next;
        diff_reg       <= diff_next;
        lo_reg         <= lo_next;
        neg_reg        <= neg_next;
        prod_reg       <= prod_next;
        if (chan_done) begin
            lvl_reg[ch_reg] <= chan_level;
        end
        if ((state_reg == scl_pkg::ST_FIN) && out_free) begin
            red_reg   <= lvl_reg[0];
            green_reg <= lvl_reg[1];
            blue_reg  <= lvl_reg[2];
        end
    end

    // breakpoint table: one write port for loads, one registered read for the scan
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            point_mem_reg[wr_addr] <= '{key: s_point_key, below: s_level_below,
                                        above: s_level_above};
        end
        rd_data_reg <= point_mem_reg[rd_addr];
    end

    // checks on the sequencer and interpolation
    `SCL_ASSERT_SAME(a_scan_in_range, aclk, aresetn, state_reg == scl_pkg::ST_READ,
        i_ext < n_use, "scan index past last point")
    `SCL_ASSERT_SAME(a_prev_key_le, aclk, aresetn,
        (state_reg == scl_pkg::ST_CHECK) && key_hit && (i_reg != '0),
        prev_key_reg <= sample_reg, "lower key above sample")
    `SCL_ASSERT_SAME(a_quot_bound, aclk, aresetn,
        (state_reg == scl_pkg::ST_DIV) && div_stat.done,
        div_quot <= diff_reg, "step exceeds level difference")
    `SCL_ASSERT_SAME(a_div_free, aclk, aresetn, div_start, !div_stat.busy,
        "divider restarted while busy")
    `SCL_ASSERT_NEXT(a_fin_loads, aclk, aresetn, (state_reg == scl_pkg::ST_FIN) && out_free,
        m_valid_reg && (state_reg == scl_pkg::ST_IDLE), "result not presented")

endmodule

`default_nettype wire

@@ rtl/core/scl_divider.sv @@
// restoring divider, one quotient bit per cycle, quotient known to fit DATA_W
// depends on scl_pkg
`timescale 1ns / 1ps
`default_nettype none

module scl_divider (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [scl_pkg::PROD_W-1:0] dividend,
    input  wire logic [scl_pkg::DATA_W-1:0] divisor,
    output scl_pkg::level_t                 quotient,
    output scl_pkg::div_status_t            status
);

    logic [scl_pkg::DATA_W-1:0]    rem_reg, rem_next;
    logic [scl_pkg::DATA_W-1:0]    quo_reg, quo_next;
    logic [scl_pkg::DATA_W-1:0]    dvs_reg, dvs_next;
    logic [scl_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [scl_pkg::DATA_W:0]      partial;
    logic [scl_pkg::DATA_W:0]      trial;

    // load the operands on start, else shift in the next dividend bit and try the subtraction
    always_comb begin
        partial   = {rem_reg, quo_reg[scl_pkg::DATA_W-1]};
        trial     = partial - {1'b0, dvs_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            // upper half is below the divisor, so only DATA_W steps remain
            rem_next  = dividend[scl_pkg::PROD_W-1:scl_pkg::DATA_W];
            quo_next  = dividend[scl_pkg::DATA_W-1:0];
            dvs_next  = divisor;
            cnt_next  = scl_pkg::DIV_CNT_W'(scl_pkg::DIV_STEPS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[scl_pkg::DATA_W]) begin
                rem_next = trial[scl_pkg::DATA_W-1:0];
                quo_next = {quo_reg[scl_pkg::DATA_W-2:0], 1'b1};
            end else begin
                rem_next = partial[scl_pkg::DATA_W-1:0];
                quo_next = {quo_reg[scl_pkg::DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == scl_pkg::DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

`default_nettype wire
